FILE: rtl/rfo_pkg.sv
// Shared types and constants of the ring FIFO with overwrite.
package rfo_pkg;

    // Stream payload widths (packed fields padded to whole bytes)
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 80;

    // Configuration port widths
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;

    // Field widths
    localparam int OP_W    = 3;
    localparam int DATA_W  = 64;
    localparam int LEN_W   = 4;
    localparam int CNT_W   = 6;
    localparam int BYTES_W = 4;
    localparam int DATA_BYTES = DATA_W / 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 3'd0;
    localparam logic [OP_W-1:0] OP_FORCE = 3'd1;
    localparam logic [OP_W-1:0] OP_GET   = 3'd2;
    localparam logic [OP_W-1:0] OP_FLUSH = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ITEM_BYTES = 4'd1;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;   // accepted item: update indices, load result fields
        logic fill;   // memory read data is ready: load data_out
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pop;    // the presented item is a get on a non-empty buffer
    } dp_stat_t;

endpackage

FILE: rtl/rfo_ctrl.sv
// Controller state machine: input/output handshakes and the get read phase.
module rfo_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  rfo_pkg::dp_stat_t  stat,
    output rfo_pkg::ctrl_cmd_t cmd
);

    rfo_pkg::state_t state_reg;
    rfo_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            accept;

    // Hold state and result-valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rfo_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        s_tready       = (state_reg == rfo_pkg::ST_IDLE) && (!out_valid_reg || m_tready);
        accept         = s_tvalid && s_tready;
        cmd.load       = accept;
        cmd.fill       = (state_reg == rfo_pkg::ST_READ);
        state_next     = state_reg;
        out_valid_next = out_valid_reg;

        case (state_reg)
            rfo_pkg::ST_IDLE:
            begin
                if (accept && stat.pop)
                begin
                    state_next = rfo_pkg::ST_READ;
                end
            end
            rfo_pkg::ST_READ:
            begin
                state_next = rfo_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rfo_pkg::ST_IDLE;
            end
        endcase

        // Advance the result-valid flag
        if (cmd.fill)
        begin
            out_valid_next = 1'b1;
        end
        else if (accept)
        begin
            out_valid_next = !stat.pop;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

FILE: rtl/rfo_datapath.sv
// Datapath: registers, ring indices, slot memory and result registers.
module rfo_datapath
#(
    parameter int MAX_ITEMS      = 63,
    parameter int MAX_ITEM_BYTES = 8,
    parameter int IDX_W          = $clog2(MAX_ITEMS + 1)
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr,
    input  logic [rfo_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rfo_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [rfo_pkg::OP_W-1:0]            op,
    input  logic [rfo_pkg::DATA_W-1:0]          data_in,
    input  logic [rfo_pkg::LEN_W-1:0]           byte_len,
    input  rfo_pkg::ctrl_cmd_t                  cmd,
    output rfo_pkg::dp_stat_t                   stat,
    output logic                                ok,
    output logic [rfo_pkg::DATA_W-1:0]          data_out,
    output logic [rfo_pkg::CNT_W-1:0]           item_count,
    output logic [rfo_pkg::CNT_W-1:0]           free_space,
    output logic                                is_empty,
    output logic                                is_full
);

    localparam int DEPTH = MAX_ITEMS + 1;
    localparam int CAP_RESET_INT = (MAX_ITEMS < 16) ? MAX_ITEMS : 16;
    localparam logic [IDX_W-1:0] CAP_RESET = IDX_W'(CAP_RESET_INT);
    localparam logic [rfo_pkg::BYTES_W-1:0] IB_RESET = 4'd8;

    // Configuration and ring state
    logic [IDX_W-1:0]            cap_reg;
    logic [rfo_pkg::BYTES_W-1:0] ib_reg;
    logic [IDX_W-1:0]            wr_reg;
    logic [IDX_W-1:0]            wr_next;
    logic [IDX_W-1:0]            rd_reg;
    logic [IDX_W-1:0]            rd_next;

    // Slot memory
    logic [rfo_pkg::DATA_W-1:0]  mem [DEPTH];
    logic [rfo_pkg::DATA_W-1:0]  rd_data_reg;

    // Result registers
    logic                        ok_reg;
    logic                        ok_next;
    logic [rfo_pkg::DATA_W-1:0]  data_out_reg;
    logic [rfo_pkg::CNT_W-1:0]   count_reg;
    logic [rfo_pkg::CNT_W-1:0]   free_reg;
    logic                        empty_reg;
    logic                        full_reg;
    logic [rfo_pkg::LEN_W-1:0]   get_len_reg;

    // Step logic
    logic [rfo_pkg::BYTES_W-1:0] ib_eff;
    logic [rfo_pkg::LEN_W-1:0]   len_eff;
    logic [rfo_pkg::DATA_BYTES-1:0] wr_be;
    logic                        wr_en;
    logic                        rd_en;
    logic                        empty_now;
    logic                        full_now;
    logic [IDX_W-1:0]            free_n;
    logic [IDX_W-1:0]            count_n;
    logic [rfo_pkg::DATA_W-1:0]  get_mask;
    logic [IDX_W-1:0]            cap_wr;

    function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx,
                                                   input logic [IDX_W-1:0] cap);
        step_down = (idx == '0) ? cap : (idx - 1'b1);
    endfunction

    // Clamp the written capacity to MAX_ITEMS
    always_comb
    begin
        if (int'(cfg_data[rfo_pkg::CNT_W-1:0]) > MAX_ITEMS)
        begin
            cap_wr = IDX_W'(MAX_ITEMS);
        end
        else
        begin
            cap_wr = IDX_W'(cfg_data[rfo_pkg::CNT_W-1:0]);
        end
    end

    // Effective item size and copy length
    always_comb
    begin
        if (ib_reg == '0)
        begin
            ib_eff = 4'd1;
        end
        else if (int'(ib_reg) > MAX_ITEM_BYTES)
        begin
            ib_eff = rfo_pkg::BYTES_W'(MAX_ITEM_BYTES);
        end
        else
        begin
            ib_eff = ib_reg;
        end

        if (byte_len == '0 || byte_len > ib_eff)
        begin
            len_eff = ib_eff;
        end
        else
        begin
            len_eff = byte_len;
        end

        for (int b = 0; b < rfo_pkg::DATA_BYTES; b++)
        begin
            wr_be[b] = (rfo_pkg::LEN_W'(b) < len_eff);
        end
    end

    // Execute one operation on the ring indices
    always_comb
    begin
        empty_now = (rd_reg == wr_reg);
        full_now  = (step_down(wr_reg, cap_reg) == rd_reg);
        wr_next   = wr_reg;
        rd_next   = rd_reg;
        ok_next   = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;

        case (op)
            rfo_pkg::OP_PUT:
            begin
                if (!full_now)
                begin
                    wr_en   = 1'b1;
                    wr_next = step_down(wr_reg, cap_reg);
                    ok_next = 1'b1;
                end
            end
            rfo_pkg::OP_FORCE:
            begin
                // With a nonzero capacity, drop the oldest item when full, then always store
                if (cap_reg != '0)
                begin
                    if (full_now)
                    begin
                        rd_next = step_down(rd_reg, cap_reg);
                        ok_next = 1'b1;
                    end
                    wr_en   = 1'b1;
                    wr_next = step_down(wr_reg, cap_reg);
                end
            end
            rfo_pkg::OP_GET:
            begin
                if (!empty_now)
                begin
                    rd_en   = 1'b1;
                    rd_next = step_down(rd_reg, cap_reg);
                    ok_next = 1'b1;
                end
            end
            rfo_pkg::OP_FLUSH:
            begin
                rd_next = wr_reg;
                ok_next = 1'b1;
            end
            rfo_pkg::OP_QUERY:
            begin
                ok_next = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase

        // Fill state after the step
        if (rd_next >= wr_next)
        begin
            free_n = cap_reg - (rd_next - wr_next);
        end
        else
        begin
            free_n = wr_next - rd_next - 1'b1;
        end
        count_n = cap_reg - free_n;

        stat.pop = (op == rfo_pkg::OP_GET) && !empty_now;
    end

    // Zero the bytes above the requested get length
    always_comb
    begin
        for (int b = 0; b < rfo_pkg::DATA_BYTES; b++)
        begin
            get_mask[b*8 +: 8] = (rfo_pkg::LEN_W'(b) < get_len_reg) ? 8'hFF : 8'h00;
        end
    end

    // Hold configuration and ring indices
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
            ib_reg  <= IB_RESET;
            wr_reg  <= CAP_RESET;
            rd_reg  <= CAP_RESET;
        end
        else if (cfg_wr)
        begin
            if (cfg_index == rfo_pkg::CFG_CAPACITY)
            begin
                cap_reg <= cap_wr;
                wr_reg  <= cap_wr;
                rd_reg  <= cap_wr;
            end
            else if (cfg_index == rfo_pkg::CFG_ITEM_BYTES)
            begin
                ib_reg <= cfg_data[rfo_pkg::BYTES_W-1:0];
            end
        end
        else if (cmd.load)
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
        end
    end

    // Slot memory: byte-enabled write, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load && wr_en)
        begin
            for (int b = 0; b < rfo_pkg::DATA_BYTES; b++)
            begin
                if (wr_be[b])
                begin
                    mem[wr_reg][b*8 +: 8] <= data_in[b*8 +: 8];
                end
            end
        end
        if (cmd.load && rd_en)
        begin
            rd_data_reg <= mem[rd_reg];
        end
    end

    // Load the result fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ok_reg       <= ok_next;
            data_out_reg <= '0;
            count_reg    <= rfo_pkg::CNT_W'(count_n);
            free_reg     <= rfo_pkg::CNT_W'(free_n);
            empty_reg    <= (rd_next == wr_next);
            full_reg     <= (step_down(wr_next, cap_reg) == rd_next);
            get_len_reg  <= len_eff;
        end
        else if (cmd.fill)
        begin
            data_out_reg <= rd_data_reg & get_mask;
        end
    end

    assign ok         = ok_reg;
    assign data_out   = data_out_reg;
    assign item_count = count_reg;
    assign free_space = free_reg;
    assign is_empty   = empty_reg;
    assign is_full    = full_reg;

endmodule

FILE: rtl/ring_fifo_with_overwrite_core.sv
// Top level of the ring FIFO with overwrite: stream ports, config port, assertions.
//
// Each transfer on the input stream carries one operation (put, force put, get,
// flush or status query) and yields exactly one result transfer with ok, the
// popped data and the fill state after the operation. Put, force put, flush,
// query and a get on an empty buffer load the result directly; a get that pops
// waits in the read state for the registered memory read. The result sits in an
// output register, so the next operation is taken in the same cycle that the
// pending result transfers. Items live in MAX_ITEMS+1 slots of 64 bits; writing
// the capacity register empties the buffer. The configuration port is always
// ready and may be written only while no operation is in flight.
module ring_fifo_with_overwrite_core
#(
    parameter int MAX_ITEMS      = 63,
    parameter int MAX_ITEM_BYTES = 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // s_tdata, lowest bit up: op[2:0], data_in[66:3], byte_len[70:67], zero pad
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rfo_pkg::IN_TDATA_W-1:0]      s_tdata,
    // m_tdata, lowest bit up: ok[0], data_out[64:1], item_count[70:65],
    // free_space[76:71], is_empty[77], is_full[78], zero pad
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rfo_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // Register write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rfo_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rfo_pkg::CFG_DATA_W-1:0]      cfg_data
);

    rfo_pkg::ctrl_cmd_t             cmd;
    rfo_pkg::dp_stat_t              stat;
    logic                           ok;
    logic [rfo_pkg::DATA_W-1:0]     data_out;
    logic [rfo_pkg::CNT_W-1:0]      item_count;
    logic [rfo_pkg::CNT_W-1:0]      free_space;
    logic                           is_empty;
    logic                           is_full;

    assign cfg_ready = 1'b1;

    // Controller
    rfo_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath
    rfo_datapath
    #(
        .MAX_ITEMS      (MAX_ITEMS),
        .MAX_ITEM_BYTES (MAX_ITEM_BYTES)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .op         (s_tdata[2:0]),
        .data_in    (s_tdata[66:3]),
        .byte_len   (s_tdata[70:67]),
        .cmd        (cmd),
        .stat       (stat),
        .ok         (ok),
        .data_out   (data_out),
        .item_count (item_count),
        .free_space (free_space),
        .is_empty   (is_empty),
        .is_full    (is_full)
    );

    // Pack the result transfer
    assign m_tdata = {1'b0, is_full, is_empty, free_space, item_count, data_out, ok};

    // No new transfer is taken while a result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result stalled");

    // A non-popping operation shows its result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && !stat.pop) |=> m_tvalid)
        else $error("result missing after operation");

    // A popping get shows its result after the memory read
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && stat.pop) |=> (!m_tvalid ##1 m_tvalid))
        else $error("get result timing wrong");

    // An empty buffer holds no items
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && is_empty) |-> (item_count == '0))
        else $error("empty buffer reports items");

endmodule

FILE: verif/tb.sv
// Self-checking stream testbench for the ring FIFO with overwrite core.
`timescale 1ns / 100ps

module tb;
    import rfo_pkg::*;

    typedef logic [OP_W-1:0] op_t;

    localparam int  CAP_AT_RESET = 16;
    localparam int  SLOTS        = 64;
    localparam int  PHASES       = 12;
    // Codes above the last defined operation leave the ring unchanged and reply with ok low
    localparam op_t OP_BAD_LO    = OP_QUERY + 3'd1;
    localparam op_t OP_BAD_HI    = 3'd7;

    // One status reply as the block reports it
    typedef struct {
        bit              ok;
        bit [DATA_W-1:0] data;
        bit [CNT_W-1:0]  count;
        bit [CNT_W-1:0]  space;
        bit              empty;
        bit              full;
    } fifo_reply_t;

    // Shadow copy of the ring: indices, slots and registers, plus the replies still owed
    class fifo_mirror;
        bit [CNT_W-1:0]   cap;
        bit [BYTES_W-1:0] ib;
        bit [CNT_W-1:0]   wr;
        bit [CNT_W-1:0]   rd;
        bit [DATA_W-1:0]  slots [SLOTS];
        bit               seen  [SLOTS];
        fifo_reply_t      replies [$];
        int               bad_count;

        function new();
            cap = CNT_W'(CAP_AT_RESET);
            ib  = BYTES_W'(DATA_BYTES);
            wr  = cap;
            rd  = cap;
            bad_count = 0;
            foreach (seen[i])
            begin
                seen[i]  = 1'b0;
                slots[i] = '0;
            end
        endfunction

        function bit [CNT_W-1:0] step_down(bit [CNT_W-1:0] idx);
            return (idx == 0) ? cap : idx - 1'b1;
        endfunction

        function int free_now();
            if (rd >= wr)
                return cap - (rd - wr);
            return wr - rd - 1;
        endfunction

        // Byte mask for a transfer length; zero or oversize means the whole item
        function bit [DATA_W-1:0] len_mask(bit [LEN_W-1:0] len);
            int sz;
            int n;
            sz = (ib == 0) ? 1 : ((ib > DATA_BYTES) ? DATA_BYTES : ib);
            n  = (len == 0 || len > sz) ? sz : len;
            if (n >= DATA_BYTES)
                return '1;
            return (64'd1 << (8 * n)) - 64'd1;
        endfunction

        // Store unless full; upper bytes outside the mask keep their old value
        function bit store(bit [DATA_W-1:0] data, bit [LEN_W-1:0] len);
            bit [DATA_W-1:0] m;
            if (step_down(wr) == rd)
                return 1'b0;
            m = len_mask(len);
            slots[wr] = (slots[wr] & ~m) | (data & m);
            seen[wr]  = 1'b1;
            wr = step_down(wr);
            return 1'b1;
        endfunction

        // Capacity writes keep only the low CNT_W bits and empty the ring
        function void apply_config(bit [CFG_INDEX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
            if (idx == CFG_CAPACITY)
            begin
                cap = val[CNT_W-1:0];
                wr  = cap;
                rd  = cap;
            end
            else if (idx == CFG_ITEM_BYTES)
                ib = val[BYTES_W-1:0];
        endfunction

        // Advance the shadow ring by one accepted operation and queue its reply
        function void apply_op(op_t op, bit [DATA_W-1:0] data, bit [LEN_W-1:0] len);
            fifo_reply_t r;
            int          fs;
            r = '{default: '0};
            case (op)
                OP_PUT:   r.ok = store(data, len);
                OP_FORCE:
                begin
                    if (cap != 0)
                    begin
                        if (step_down(wr) == rd)
                        begin
                            rd   = step_down(rd);
                            r.ok = 1'b1;
                        end
                        void'(store(data, len));
                    end
                end
                OP_GET:
                begin
                    if (rd != wr)
                    begin
                        r.data = slots[rd] & len_mask(len);
                        rd     = step_down(rd);
                        r.ok   = 1'b1;
                    end
                end
                OP_FLUSH:
                begin
                    rd   = wr;
                    r.ok = 1'b1;
                end
                OP_QUERY: r.ok = 1'b1;
                default: ;
            endcase
            fs      = free_now();
            r.space = CNT_W'(fs);
            r.count = CNT_W'(cap - fs);
            r.empty = (rd == wr);
            r.full  = (step_down(wr) == rd);
            replies.push_back(r);
        endfunction

        function void diff(string fld, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
                bad_count++;
            end
        endfunction

        // Compare one result transfer with the oldest owed reply
        function void match_reply(logic [OUT_TDATA_W-1:0] t);
            fifo_reply_t want;
            if (replies.size() == 0)
            begin
                $display("%0t: result with nothing owed, expected none, actual %0h", $time, t);
                bad_count++;
                return;
            end
            want = replies.pop_front();
            diff("ok",         DATA_W'(want.ok),    DATA_W'(t[0]));
            diff("data_out",   want.data,           t[64:1]);
            diff("item_count", DATA_W'(want.count), DATA_W'(t[70:65]));
            diff("free_space", DATA_W'(want.space), DATA_W'(t[76:71]));
            diff("is_empty",   DATA_W'(want.empty), DATA_W'(t[77]));
            diff("is_full",    DATA_W'(want.full),  DATA_W'(t[78]));
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // op, data_in, byte_len, zero pad
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // ok, data_out, item_count, free_space, is_empty, is_full
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    fifo_mirror mirror = new();
    int         src_idle_pct  = 20;
    int         sink_idle_pct = 20;
    int         phase_cap [PHASES] = '{1, 63, 0, 63, 2, -1, -1, 1, -1, 63, -1, -1};
    int         phase_ib  [PHASES] = '{8, 1, 4, 8, 0, 15, -1, -1, -1, 3, -1, -1};

    ring_fifo_with_overwrite_core u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap(int pct);
        if (pct == 0 || $urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Present one operation, hold it until the transfer, then log it in the mirror
    task automatic push_op(op_t op, logic [DATA_W-1:0] data, logic [LEN_W-1:0] len);
        int gap;
        gap = pick_gap(src_idle_pct);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({len, data, op});
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        mirror.apply_op(op, data, len);
        @(negedge clk);
    endtask

    // Write one register; call only with the block idle
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        mirror.apply_config(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid and wait until every owed reply has arrived, plus a short tail
    task automatic settle();
        s_tvalid <= 1'b0;
        while (mirror.replies.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Result side: stall at random
    initial
    begin : sink
        int hold;
        hold = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                hold = pick_gap(sink_idle_pct);
                if (hold > 0)
                begin
                    hold--;
                    m_tready <= 1'b0;
                end
                else
                    m_tready <= 1'b1;
            end
        end
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            mirror.match_reply(m_tdata);
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        op_t                   op;
        int                    cap_v;
        int                    ib_v;
        int                    put_pct;
        int                    r;
        logic [CFG_DATA_W-1:0] cfg_word;
        logic [LEN_W-1:0]      len;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset state, empty get, full-length put and get
        push_op(OP_QUERY, '0, '0);
        push_op(OP_GET, '0, '0);
        push_op(OP_FLUSH, '0, '0);
        push_op(OP_PUT, '1, '0);
        push_op(OP_PUT, 64'h0123_4567_89ab_cdef, 4'd8);
        push_op(OP_GET, '0, 4'd15);
        push_op(OP_GET, '0, '0);

        // Fill to the deepest capacity, overwrite when full, drain; every slot gets written
        settle();
        write_reg(CFG_CAPACITY, 8'd63);
        write_reg(CFG_ITEM_BYTES, 8'd8);
        repeat (63) push_op(OP_PUT, {$urandom, $urandom}, '0);
        push_op(OP_PUT, '1, '0);
        push_op(OP_FORCE, '0, '0);
        repeat (63) push_op(OP_GET, '0, '0);
        push_op(OP_GET, '0, '0);

        // Short items: partial put keeps upper bytes, short and oversize get lengths
        settle();
        write_reg(CFG_ITEM_BYTES, 8'd3);
        push_op(OP_PUT, '0, '0);
        push_op(OP_PUT, '1, 4'd2);
        push_op(OP_FORCE, '1, 4'd9);
        push_op(OP_GET, '0, 4'd1);
        push_op(OP_GET, '0, 4'd9);
        push_op(OP_PUT, '1, '0);
        push_op(OP_FLUSH, '0, '0);
        for (int k = OP_BAD_LO; k <= OP_BAD_HI; k++)
            push_op(op_t'(k), '1, '1);

        // Unused register indexes must change nothing
        settle();
        for (int k = CFG_ITEM_BYTES + 1; k < (1 << CFG_INDEX_W); k++)
            write_reg(CFG_INDEX_W'(k), CFG_DATA_W'($urandom));
        push_op(OP_QUERY, '0, '0);

        // Zero capacity: always empty and full at once
        settle();
        write_reg(CFG_CAPACITY, 8'h00);
        push_op(OP_PUT, '1, '0);
        push_op(OP_FORCE, '1, '0);
        push_op(OP_GET, '0, '0);
        push_op(OP_FLUSH, '0, '0);

        // Capacity one, written with the upper data bits set
        settle();
        write_reg(CFG_CAPACITY, 8'hC1);
        push_op(OP_PUT, {$urandom, $urandom}, '0);
        push_op(OP_PUT, {$urandom, $urandom}, '0);
        push_op(OP_FORCE, {$urandom, $urandom}, '0);
        push_op(OP_GET, '0, '0);
        push_op(OP_GET, '0, '0);

        // Random phases, each with its own register setting, fill bias and idle mix
        for (int p = 0; p < PHASES; p++)
        begin
            cap_v = (phase_cap[p] < 0) ? $urandom_range(1, 63) : phase_cap[p];
            ib_v  = (phase_ib[p] < 0) ? $urandom_range(0, 15) : phase_ib[p];
            settle();
            cfg_word = CFG_DATA_W'($urandom);
            cfg_word[CNT_W-1:0] = CNT_W'(cap_v);
            write_reg(CFG_CAPACITY, cfg_word);
            cfg_word = CFG_DATA_W'($urandom);
            cfg_word[BYTES_W-1:0] = BYTES_W'(ib_v);
            write_reg(CFG_ITEM_BYTES, cfg_word);
            src_idle_pct  = (p % 3 == 0) ? 0 : $urandom_range(10, 40);
            sink_idle_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 40);
            put_pct = (cap_v == 63) ? 55 : $urandom_range(25, 55);
            repeat ((cap_v == 0) ? 20 : 85)
            begin
                r = $urandom_range(99);
                if (r < put_pct)
                    op = OP_PUT;
                else if (r < put_pct + 15)
                    op = OP_FORCE;
                else if (r < 88)
                    op = OP_GET;
                else if (r < 91)
                    op = OP_FLUSH;
                else if (r < 95)
                    op = OP_QUERY;
                else
                    op = op_t'($urandom_range(OP_BAD_LO, OP_BAD_HI));
                // Never pop a slot that has not been written
                if (op == OP_GET && mirror.rd != mirror.wr && !mirror.seen[mirror.rd])
                    op = OP_QUERY;
                len = ($urandom_range(1) == 0) ? '0 : LEN_W'($urandom_range(0, 15));
                push_op(op, {$urandom, $urandom}, len);
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (mirror.bad_count == 0 && mirror.replies.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
